/* rtl/core/assert_macros.svh */
// assertion macros shared by the parser rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PHFP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PHFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PHFP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define PHFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/phfp_pkg.sv */
// shared types, constants and byte classification for the header parser
// no dependencies
package phfp_pkg;

	localparam logic [4:0] MIN_BYTES = 5'd26;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SHORT   = 2'd1;
	localparam logic [1:0] ST_BAD_SID = 2'd2;
	localparam logic [1:0] ST_BAD_TS  = 2'd3;

	localparam logic [1:0] CODE_BAD = 2'd3;

	// destination of one byte
	typedef enum logic [3:0] {
		FLD_NONE,
		FLD_FIRST,
		FLD_KIND,
		FLD_FLAGS,
		FLD_SESS,
		FLD_SEQ,
		FLD_ACK,
		FLD_STAMP,
		FLD_LEN
	} field_t;

	// one classified byte between front and back
	typedef struct packed {
		logic [7:0] data;
		field_t     field;
		logic       last;
		logic       full;
	} entry_t;

	// session id size in bytes
	function automatic logic [4:0] sid_bytes(input logic [1:0] code);
		logic [4:0] n;
		case (code)
			2'd0:    n = 5'd2;
			2'd1:    n = 5'd4;
			default: n = 5'd8;
		endcase
		return n;
	endfunction

	// timestamp size in bytes
	function automatic logic [4:0] ts_bytes(input logic [1:0] code);
		logic [4:0] n;
		case (code)
			2'd0:    n = 5'd2;
			2'd1:    n = 5'd3;
			default: n = 5'd4;
		endcase
		return n;
	endfunction

	// field that the byte at a header offset belongs to
	function automatic field_t classify(input logic [4:0] pos, input logic [1:0] sid_code,
		input logic [1:0] ts_code);
		logic [4:0] seq_at;
		logic [4:0] ack_at;
		logic [4:0] ts_at;
		logic [4:0] len_at;
		field_t f;
		seq_at = 5'd4 + sid_bytes(sid_code);
		ack_at = seq_at + 5'd4;
		ts_at  = ack_at + 5'd4;
		len_at = ts_at + ts_bytes(ts_code);
		if (pos == 5'd0) f = FLD_FIRST;
		else if (pos == 5'd1) f = FLD_KIND;
		else if (pos == 5'd2) f = FLD_NONE;
		else if (pos == 5'd3) f = FLD_FLAGS;
		else if (pos < seq_at) f = FLD_SESS;
		else if (pos < ack_at) f = FLD_SEQ;
		else if (pos < ts_at) f = FLD_ACK;
		else if (pos < len_at) f = FLD_STAMP;
		else if (pos < len_at + 5'd2) f = FLD_LEN;
		else f = FLD_NONE;
		return f;
	endfunction

endpackage

/* rtl/core/phfp_in_if.sv */
// byte channel into the header parser
// no dependencies
interface phfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/core/phfp_out_if.sv */
// result channel out of the header parser
// no dependencies
interface phfp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  version;
	logic [1:0]  session_size_code;
	logic [7:0]  packet_kind;
	logic [7:0]  flag_bits;
	logic [63:0] session_ident;
	logic [31:0] sequence_num;
	logic [31:0] ack_num;
	logic [31:0] time_stamp;
	logic [15:0] payload_len;

	modport source (output valid, output status, output version, output session_size_code,
		output packet_kind, output flag_bits, output session_ident, output sequence_num,
		output ack_num, output time_stamp, output payload_len, input ready);
	modport sink (input valid, input status, input version, input session_size_code,
		input packet_kind, input flag_bits, input session_ident, input sequence_num,
		input ack_num, input time_stamp, input payload_len, output ready);
endinterface

/* rtl/core/phfp_front.sv */
// front end: takes bytes, tracks the offset and tags each byte with its field
// depends on phfp_pkg and phfp_in_if
module phfp_front (
	input  logic            clk,
	input  logic            arst_n,
	phfp_in_if.sink         pkt,
	input  logic            q_ready,
	output logic            q_push,
	output phfp_pkg::entry_t q_entry
);
	import phfp_pkg::*;

	logic [4:0] count_q;
	logic [1:0] sid_code_q;
	logic [1:0] ts_code_q;
	logic [4:0] count_next;
	logic       accept;

	assign pkt.ready = q_ready;
	assign accept    = pkt.valid && q_ready;
	assign q_push    = accept;

	// saturating byte count
	assign count_next = (count_q < MIN_BYTES) ? count_q + 5'd1 : count_q;

	// tag the byte
	always_comb begin
		q_entry.data  = pkt.data_byte;
		q_entry.last  = pkt.last_byte;
		q_entry.full  = (count_next == MIN_BYTES);
		q_entry.field = (count_q < MIN_BYTES) ? classify(count_q, sid_code_q, ts_code_q)
			: FLD_NONE;
	end

	// offset and size codes of the current packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			sid_code_q <= '0;
			ts_code_q  <= '0;
		end else if (accept) begin
			if (pkt.last_byte) begin
				count_q    <= '0;
				sid_code_q <= '0;
				ts_code_q  <= '0;
			end else begin
				count_q <= count_next;
				if (count_q == 5'd0) begin
					sid_code_q <= pkt.data_byte[3:2];
					ts_code_q  <= pkt.data_byte[1:0];
				end
			end
		end
	end
endmodule

/* rtl/core/phfp_queue.sv */
// two-entry queue of tagged bytes between front and back
// depends on phfp_pkg
module phfp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  phfp_pkg::entry_t push_entry,
	output logic             push_ready,
	input  logic             pop,
	output logic             head_valid,
	output phfp_pkg::entry_t head
);
	import phfp_pkg::*;

	entry_t     slots_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign push_ready = (cnt_q != 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = slots_q[rd_ptr_q];

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

/* rtl/core/phfp_back.sv */
// back end: gathers field bytes and registers one result per packet
// depends on phfp_pkg, phfp_out_if and assert_macros.svh
`include "assert_macros.svh"
module phfp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  phfp_pkg::entry_t head,
	output logic             pop,
	phfp_out_if.source       res
);
	import phfp_pkg::*;

	logic [7:0]  first_q, kind_q, flags_q;
	logic [63:0] sess_q;
	logic [31:0] seq_q, ack_q, stamp_q;
	logic [15:0] len_q;
	logic [7:0]  first_n, kind_n, flags_n;
	logic [63:0] sess_n;
	logic [31:0] seq_n, ack_n, stamp_n;
	logic [15:0] len_n;
	logic [1:0]  status_n;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || res.ready;
	assign pop       = head_valid && (!head.last || slot_free);
	assign res.valid = out_valid_q;

	// field values including the byte at the head
	always_comb begin
		first_n = (head.field == FLD_FIRST) ? head.data : first_q;
		kind_n  = (head.field == FLD_KIND) ? head.data : kind_q;
		flags_n = (head.field == FLD_FLAGS) ? head.data : flags_q;
		sess_n  = (head.field == FLD_SESS) ? {sess_q[55:0], head.data} : sess_q;
		seq_n   = (head.field == FLD_SEQ) ? {seq_q[23:0], head.data} : seq_q;
		ack_n   = (head.field == FLD_ACK) ? {ack_q[23:0], head.data} : ack_q;
		stamp_n = (head.field == FLD_STAMP) ? {stamp_q[23:0], head.data} : stamp_q;
		len_n   = (head.field == FLD_LEN) ? {len_q[7:0], head.data} : len_q;
		if (!head.full) status_n = ST_SHORT;
		else if (first_n[3:2] == CODE_BAD) status_n = ST_BAD_SID;
		else if (first_n[1:0] == CODE_BAD) status_n = ST_BAD_TS;
		else status_n = ST_OK;
	end

	// accumulators, cleared at end of packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			kind_q  <= '0;
			flags_q <= '0;
			sess_q  <= '0;
			seq_q   <= '0;
			ack_q   <= '0;
			stamp_q <= '0;
			len_q   <= '0;
		end else if (pop) begin
			if (head.last) begin
				first_q <= '0;
				kind_q  <= '0;
				flags_q <= '0;
				sess_q  <= '0;
				seq_q   <= '0;
				ack_q   <= '0;
				stamp_q <= '0;
				len_q   <= '0;
			end else begin
				first_q <= first_n;
				kind_q  <= kind_n;
				flags_q <= flags_n;
				sess_q  <= sess_n;
				seq_q   <= seq_n;
				ack_q   <= ack_n;
				stamp_q <= stamp_n;
				len_q   <= len_n;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, zeroed on error
	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			res.status <= status_n;
			if (status_n == ST_OK) begin
				res.version           <= first_n[7:4];
				res.session_size_code <= first_n[3:2];
				res.packet_kind       <= kind_n;
				res.flag_bits         <= flags_n;
				res.session_ident     <= sess_n;
				res.sequence_num      <= seq_n;
				res.ack_num           <= ack_n;
				res.time_stamp        <= stamp_n;
				res.payload_len       <= len_n;
			end else begin
				res.version           <= '0;
				res.session_size_code <= '0;
				res.packet_kind       <= '0;
				res.flag_bits         <= '0;
				res.session_ident     <= '0;
				res.sequence_num      <= '0;
				res.ack_num           <= '0;
				res.time_stamp        <= '0;
				res.payload_len       <= '0;
			end
		end
	end

	// checks
	`PHFP_ASSERT_NEXT(a_last_gives_result, clk, arst_n, pop && head.last, out_valid_q, "last item gave no result")
	`PHFP_ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, out_valid_q && !res.ready, !(pop && head.last), "held result overwritten")
	`PHFP_ASSERT_IMPLIES(a_error_zeroes, clk, arst_n, out_valid_q && res.status != ST_OK, res.session_ident == '0 && res.payload_len == '0, "error result not zeroed")
endmodule

/* rtl/core/packet_header_field_parser.sv */
// Packet header field parser. Takes one packet byte per clock and returns one
// registered result per packet, built when the byte marked last is taken;
// bytes past offset 25 only end the packet. A new byte is accepted every
// cycle as long as the result side keeps up; the result is registered when
// the back end pops its last byte, later when the queue still holds an older
// byte after a stall. A front end tags each byte with its field,
// a two-entry queue carries the tags, and a back end gathers the fields; when
// a result waits untaken the back end holds at the next packet's last byte and
// the queue then stalls the input. No reset sweep is needed.
// depends on phfp_pkg, phfp_in_if, phfp_out_if, phfp_front, phfp_queue, phfp_back
module packet_header_field_parser (
	input  logic       clk,
	input  logic       arst_n,
	phfp_in_if.sink    pkt,
	phfp_out_if.source res
);
	import phfp_pkg::*;

	logic   q_push;
	logic   q_ready;
	entry_t q_entry;
	logic   q_pop;
	logic   head_valid;
	entry_t head;

	// byte classification
	phfp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt     (pkt),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	// decoupling queue
	phfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.push_ready (q_ready),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// field collection and result
	phfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (q_pop),
		.res        (res)
	);
endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// testbench for packet_header_field_parser: byte packets in, one parsed header out per packet
// depends on phfp_pkg, phfp_in_if, phfp_out_if and the parser rtl
module tb_top;
	import phfp_pkg::*;

	localparam int unsigned RANDOM_BYTES   = 1250;
	localparam int unsigned LONG_HOLD      = 150;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 8;

	// one parsed header as the result channel carries it
	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  version;
		logic [1:0]  session_size_code;
		logic [7:0]  packet_kind;
		logic [7:0]  flag_bits;
		logic [63:0] session_ident;
		logic [31:0] sequence_num;
		logic [31:0] ack_num;
		logic [31:0] time_stamp;
		logic [15:0] payload_len;
	} hdr_result_t;

	typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAMP} fill_t;

	// one directed packet: first byte, length, content of the rest, and a
	// hand-written header where it is obvious
	typedef struct {
		logic [7:0]  first;
		int unsigned len;
		fill_t       fill;
		bit          typed;
		hdr_result_t want;
	} pkt_row_t;

	localparam hdr_result_t SHORT_HDR = '{ST_SHORT, 4'h0, 2'd0, 8'h00, 8'h00, 64'h0,
		32'h0, 32'h0, 32'h0, 16'h0};
	localparam hdr_result_t BAD_SID_HDR = '{ST_BAD_SID, 4'h0, 2'd0, 8'h00, 8'h00, 64'h0,
		32'h0, 32'h0, 32'h0, 16'h0};
	localparam hdr_result_t BAD_TS_HDR = '{ST_BAD_TS, 4'h0, 2'd0, 8'h00, 8'h00, 64'h0,
		32'h0, 32'h0, 32'h0, 16'h0};
	localparam hdr_result_t ZERO_HDR = '{ST_OK, 4'h0, 2'd0, 8'h00, 8'h00, 64'h0,
		32'h0, 32'h0, 32'h0, 16'h0};
	localparam hdr_result_t ONES_HDR = '{ST_OK, 4'hF, 2'd0, 8'hFF, 8'hFF, 64'hFFFF,
		32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF};

	pkt_row_t dir_table [16] = '{
		'{8'h00, 1,  FILL_ZERO, 1'b1, SHORT_HDR},
		'{8'h46, 25, FILL_RAMP, 1'b1, SHORT_HDR},
		'{8'h0C, 10, FILL_ONES, 1'b1, SHORT_HDR},
		'{8'h00, 26, FILL_ZERO, 1'b1, ZERO_HDR},
		'{8'hF2, 26, FILL_ONES, 1'b1, ONES_HDR},
		'{8'hFF, 26, FILL_ONES, 1'b1, BAD_SID_HDR},
		'{8'hF3, 30, FILL_ONES, 1'b1, BAD_TS_HDR},
		'{8'h0F, 26, FILL_ZERO, 1'b1, BAD_SID_HDR},
		'{8'h5A, 40, FILL_RAMP, 1'b0, '0},
		'{8'h11, 26, FILL_RAMP, 1'b0, '0},
		'{8'h24, 27, FILL_RAMP, 1'b0, '0},
		'{8'h89, 26, FILL_RAMP, 1'b0, '0},
		'{8'hA6, 26, FILL_RAMP, 1'b0, '0},
		'{8'h38, 26, FILL_RAMP, 1'b0, '0},
		'{8'h04, 26, FILL_ONES, 1'b0, '0},
		'{8'hE9, 31, FILL_RAMP, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	phfp_in_if  pkt ();
	phfp_out_if res ();

	packet_header_field_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt),
		.res    (res)
	);

	// headers still to come out, oldest first
	hdr_result_t headers_due [$];
	int unsigned mismatches = 0;
	bit          hold_request = 1'b0;

	// parser state as the predictor sees it
	int unsigned p_count = 0;
	logic [7:0]  p_first = '0;
	logic [7:0]  p_kind  = '0;
	logic [7:0]  p_flags = '0;
	logic [63:0] p_sess  = '0;
	logic [31:0] p_seq   = '0;
	logic [31:0] p_ack   = '0;
	logic [31:0] p_stamp = '0;
	logic [15:0] p_len   = '0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic report_field(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// gap length: mostly none, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// take one byte into the header model; done is set on the last byte
	task automatic parse_byte(input logic [7:0] d, input logic l, output bit done,
		output hdr_result_t r);
		int unsigned sid_len;
		int unsigned ts_len;
		int unsigned seq_at;
		int unsigned ack_at;
		int unsigned ts_at;
		int unsigned len_at;
		// field offsets follow the size codes; a bad code lays out as the largest size
		sid_len = (p_first[3:2] == 2'd0) ? 2 : (p_first[3:2] == 2'd1) ? 4 : 8;
		ts_len  = (p_first[1:0] == 2'd0) ? 2 : (p_first[1:0] == 2'd1) ? 3 : 4;
		seq_at  = 4 + sid_len;
		ack_at  = seq_at + 4;
		ts_at   = ack_at + 4;
		len_at  = ts_at + ts_len;
		if (p_count < MIN_BYTES) begin
			if (p_count == 0)
				p_first = d;
			else if (p_count == 1)
				p_kind = d;
			else if (p_count == 3)
				p_flags = d;
			else if (p_count >= 4) begin
				if (p_count < seq_at)
					p_sess = {p_sess[55:0], d};
				else if (p_count < ack_at)
					p_seq = {p_seq[23:0], d};
				else if (p_count < ts_at)
					p_ack = {p_ack[23:0], d};
				else if (p_count < len_at)
					p_stamp = {p_stamp[23:0], d};
				else if (p_count < len_at + 2)
					p_len = {p_len[7:0], d};
			end
			p_count++;
		end
		done = l;
		r = '0;
		if (l) begin
			// status priority: short, then session code, then timestamp code
			if (p_count < MIN_BYTES)
				r.status = ST_SHORT;
			else if (p_first[3:2] == CODE_BAD)
				r.status = ST_BAD_SID;
			else if (p_first[1:0] == CODE_BAD)
				r.status = ST_BAD_TS;
			else begin
				r.status            = ST_OK;
				r.version           = p_first[7:4];
				r.session_size_code = p_first[3:2];
				r.packet_kind       = p_kind;
				r.flag_bits         = p_flags;
				r.session_ident     = p_sess;
				r.sequence_num      = p_seq;
				r.ack_num           = p_ack;
				r.time_stamp        = p_stamp;
				r.payload_len       = p_len;
			end
			p_count = 0;
			p_first = '0;
			p_kind  = '0;
			p_flags = '0;
			p_sess  = '0;
			p_seq   = '0;
			p_ack   = '0;
			p_stamp = '0;
			p_len   = '0;
		end
	endtask

	// offer one byte item, wait for it to be taken, then note the header it ends
	task automatic send_byte(input logic [7:0] d, input logic l, input bit nogap,
		input bit use_want, input hdr_result_t want);
		int unsigned gap;
		bit          done;
		hdr_result_t hdr;
		gap = nogap ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			pkt.valid <= 1'b0;
		end
		@(negedge clk);
		pkt.valid     <= 1'b1;
		pkt.data_byte <= d;
		pkt.last_byte <= l;
		do
			@(posedge clk);
		while (!pkt.ready);
		parse_byte(d, l, done, hdr);
		if (done)
			headers_due.push_back(use_want ? want : hdr);
	endtask

	// stop offering until every header has come out
	task automatic drain();
		@(negedge clk);
		pkt.valid <= 1'b0;
		while (headers_due.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] row_byte(input pkt_row_t row, input int unsigned i);
		if (i == 0)
			return row.first;
		case (row.fill)
			FILL_ZERO: return 8'h00;
			FILL_ONES: return 8'hFF;
			default:   return 8'(i * 37 + 11);
		endcase
	endfunction

	// byte source: reset, directed packets, random packets, end of run
	initial begin : byte_source
		int unsigned sent;
		int unsigned npk;
		int unsigned len;
		int unsigned r;
		logic [7:0]  b0;
		bit          nogap;
		pkt.valid     = 1'b0;
		pkt.data_byte = 8'h00;
		pkt.last_byte = 1'b0;
		arst_n        = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed packets
		foreach (dir_table[k]) begin
			for (int unsigned i = 0; i < dir_table[k].len; i++)
				send_byte(row_byte(dir_table[k], i), i == dir_table[k].len - 1, 1'b0,
					dir_table[k].typed, dir_table[k].want);
		end
		drain();

		// random packets; the first few are tiny while the result side holds off
		hold_request = 1'b1;
		sent = 0;
		npk  = 0;
		while (sent < RANDOM_BYTES) begin
			r   = $urandom_range(0, 99);
			b0  = {4'($urandom_range(0, 15)), 2'($urandom_range(0, 2)),
				2'($urandom_range(0, 2))};
			len = $urandom_range(26, 32);
			if (npk < 8)
				len = $urandom_range(1, 3);
			else if (r < 10)
				len = $urandom_range(1, 25);
			else if (r < 20) begin
				if ($urandom_range(0, 1) == 1)
					b0[3:2] = CODE_BAD;
				else
					b0[1:0] = CODE_BAD;
			end else if (r < 25)
				b0 = 8'($urandom_range(0, 255));
			else if (r < 30)
				len = $urandom_range(33, 45);
			if (npk == 40)
				drain();
			nogap = ($urandom_range(0, 3) == 0);
			for (int unsigned i = 0; i < len; i++)
				send_byte((i == 0) ? b0 : 8'($urandom_range(0, 255)), i == len - 1, nogap,
					1'b0, '0);
			sent += len;
			npk++;
		end

		// wait out the last headers
		@(negedge clk);
		pkt.valid <= 1'b0;
		while (headers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// result side: random stalls, eager stretches, and one long hold-off on request
	initial begin : result_sink
		int unsigned stall_left;
		int unsigned mode_left;
		bit          eager;
		stall_left = 0;
		mode_left  = 0;
		eager      = 1'b0;
		res.ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				eager     = ($urandom_range(0, 3) == 0);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			if (hold_request) begin
				hold_request = 1'b0;
				res.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (stall_left != 0) begin
				res.ready <= 1'b0;
				stall_left--;
			end else begin
				res.ready <= 1'b1;
				if (!eager && $urandom_range(0, 2) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// compare each header item against the oldest prediction
	always @(posedge clk) begin
		hdr_result_t want;
		if (arst_n && res.valid && res.ready) begin
			if (headers_due.size() == 0)
				report_field($sformatf("header with none expected, status %0d", res.status));
			else begin
				want = headers_due.pop_front();
				if (res.status !== want.status)
					report_field($sformatf("status %h want %h", res.status, want.status));
				if (res.version !== want.version)
					report_field($sformatf("version %h want %h", res.version, want.version));
				if (res.session_size_code !== want.session_size_code)
					report_field($sformatf("session_size_code %h want %h",
						res.session_size_code, want.session_size_code));
				if (res.packet_kind !== want.packet_kind)
					report_field($sformatf("packet_kind %h want %h", res.packet_kind,
						want.packet_kind));
				if (res.flag_bits !== want.flag_bits)
					report_field($sformatf("flag_bits %h want %h", res.flag_bits,
						want.flag_bits));
				if (res.session_ident !== want.session_ident)
					report_field($sformatf("session_ident %h want %h", res.session_ident,
						want.session_ident));
				if (res.sequence_num !== want.sequence_num)
					report_field($sformatf("sequence_num %h want %h", res.sequence_num,
						want.sequence_num));
				if (res.ack_num !== want.ack_num)
					report_field($sformatf("ack_num %h want %h", res.ack_num, want.ack_num));
				if (res.time_stamp !== want.time_stamp)
					report_field($sformatf("time_stamp %h want %h", res.time_stamp,
						want.time_stamp));
				if (res.payload_len !== want.payload_len)
					report_field($sformatf("payload_len %h want %h", res.payload_len,
						want.payload_len));
			end
		end
	end

	// end the run when neither channel moves an item for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((pkt.valid && pkt.ready) || (res.valid && res.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

endmodule
